// ===== rtl/core/cnt_pkg.sv =====
// Package: widths, verdict codes, controller state and divider request/reply types for the Carmichael number test.
`default_nettype none
package cnt_pkg;
  localparam int unsigned NumberBits = 32;
  localparam int unsigned CntBits = $clog2(NumberBits + 1);

  typedef logic [NumberBits-1:0] num_t;

  typedef enum logic [1:0] {
    VerdictPass    = 2'd0,
    VerdictPrime   = 2'd1,
    VerdictSquare  = 2'd2,
    VerdictDivFail = 2'd3
  } verdict_e;

  typedef enum logic [3:0] {
    StIdle,
    StTrialDiv,
    StTrialChk,
    StQuotDiv,
    StRepeatChk,
    StNm1Div,
    StNm1Chk,
    StRestDiv,
    StRestChk,
    StDone
  } state_e;

  // request to the serial divider and its reply
  typedef struct packed {
    logic go;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quot;
    num_t rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/cnt_divider.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
`default_nettype none
module cnt_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cnt_pkg::div_req_t      req_i,
  output cnt_pkg::div_rsp_t      rsp_o
);
  import cnt_pkg::*;

  num_t quot_q, quot_d;
  num_t div_q, div_d;
  num_t rem_q, rem_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [NumberBits:0] trial;

  always_comb begin
    quot_d = quot_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumberBits-1]} - {1'b0, div_q};
    if (req_i.go) begin
      quot_d = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = CntBits'(NumberBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (!trial[NumberBits]) begin
        rem_d = trial[NumberBits-1:0];
        quot_d = {quot_q[NumberBits-2:0], 1'b1};
      end else begin
        // shifted remainder is below the divisor here, so its top bit is zero
        rem_d = {rem_q[NumberBits-2:0], quot_q[NumberBits-1]};
        quot_d = {quot_q[NumberBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/cnt_ctrl.sv =====
// Controller: trial division sequence and verdict.
`default_nettype none
module cnt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  cnt_pkg::num_t          number_i,
  output logic                   busy_o,
  output cnt_pkg::div_req_t      req_o,
  input  cnt_pkg::div_rsp_t      rsp_i,
  output logic                   valid_o,
  output logic                   is_carmichael_o,
  output logic [1:0]             verdict_o
);
  import cnt_pkg::*;

  state_e state_q, state_d;
  num_t n_q, n_d, rest_q, rest_d, d_q, d_d;
  logic comp_q, comp_d, fail_q, fail_d;
  verdict_e verd_q, verd_d;
  logic valid_q, valid_d;
  logic accept;

  assign accept = start_i && state_q == StIdle;

  // next state and datapath
  always_comb begin
    state_d = state_q;
    n_d = n_q; rest_d = rest_q; d_d = d_q;
    comp_d = comp_q; fail_d = fail_q; verd_d = verd_q;
    valid_d = 1'b0;
    unique case (state_q)
      StIdle: if (accept) begin
        n_d = number_i; rest_d = number_i; d_d = num_t'(2);
        comp_d = 1'b0; fail_d = 1'b0;
        if (number_i < num_t'(4)) begin
          verd_d = VerdictPrime;
          state_d = StDone;
        end else begin
          state_d = StTrialDiv;
        end
      end
      StTrialDiv: state_d = StTrialChk;
      StTrialChk: if (rsp_i.done) begin
        // loop ends once d exceeds rest / d
        if (d_q > rsp_i.quot) begin
          state_d = StRestDiv;
          if (!comp_q) begin
            verd_d = VerdictPrime;
            state_d = StDone;
          end else if (rest_q <= num_t'(1)) begin
            verd_d = fail_q ? VerdictDivFail : VerdictPass;
            state_d = StDone;
          end
        end else if (rsp_i.rem == '0) begin
          comp_d = 1'b1;
          rest_d = rsp_i.quot;
          state_d = StQuotDiv;
        end else begin
          d_d = d_q + 1'b1;
          state_d = StTrialDiv;
        end
      end
      StQuotDiv: state_d = StRepeatChk;
      StRepeatChk: if (rsp_i.done) begin
        if (rsp_i.rem == '0) begin
          verd_d = VerdictSquare;
          state_d = StDone;
        end else begin
          state_d = StNm1Div;
        end
      end
      StNm1Div: state_d = StNm1Chk;
      StNm1Chk: if (rsp_i.done) begin
        if (rsp_i.rem != '0) fail_d = 1'b1;
        d_d = d_q + 1'b1;
        state_d = StTrialDiv;
      end
      StRestDiv: state_d = StRestChk;
      StRestChk: if (rsp_i.done) begin
        verd_d = (fail_q || rsp_i.rem != '0) ? VerdictDivFail : VerdictPass;
        state_d = StDone;
      end
      StDone: begin
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // divider requests
  always_comb begin
    req_o.go = 1'b0;
    req_o.dividend = rest_q;
    req_o.divisor = d_q;
    unique case (state_q) inside
      StTrialDiv, StQuotDiv: req_o.go = 1'b1;
      StNm1Div: begin
        req_o.go = 1'b1;
        req_o.dividend = n_q - 1'b1;
        req_o.divisor = d_q - 1'b1;
      end
      StRestDiv: begin
        req_o.go = 1'b1;
        req_o.dividend = n_q - 1'b1;
        req_o.divisor = rest_q - 1'b1;
      end
      default: req_o.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; rest_q <= rest_d; d_q <= d_d;
    comp_q <= comp_d; fail_q <= fail_d; verd_q <= verd_d;
  end

  assign busy_o = state_q != StIdle;
  assign valid_o = valid_q;
  assign verdict_o = verd_q;
  assign is_carmichael_o = verd_q == VerdictPass;
endmodule
`default_nettype wire

// ===== rtl/core/carmichael_number_test_core.sv =====
// Top level of the Carmichael number test.
// Usage: drive number_i and raise start_i; the request is taken at a clock
// edge where start_i is high and busy_o is low. busy_o stays high while the
// number is examined. The result shows on is_carmichael_o and verdict_o
// for exactly one cycle, marked by valid_o, in the cycle where busy_o falls.
// verdict_o: 0 passes, 1 prime or below 4, 2 repeated prime factor,
// 3 n-1 not divisible by p-1 for some prime factor p.
// Work: candidate divisors d run up to sqrt of the remaining cofactor; each
// costs one pass of the bit-serial divider, a found factor costs two more
// passes, and the leftover prime one more.
// One number at a time; the single shared divider sets the rate.
// Reset returns the controller to idle and drops any number in progress.
// The receiver cannot stall: results are never held.
`default_nettype none
module carmichael_number_test_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [cnt_pkg::NumberBits-1:0] number_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output logic                   is_carmichael_o,
  output logic [1:0]             verdict_o
);
  import cnt_pkg::*;

  div_req_t req;
  div_rsp_t rsp;

  cnt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .number_i, .busy_o,
    .req_o(req), .rsp_i(rsp),
    .valid_o, .is_carmichael_o, .verdict_o
  );

  cnt_divider u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));
endmodule
`default_nettype wire

// ===== rtl/core/cnt_checker.sv =====
// Port-level checker for the Carmichael number test, bound to the top level.
`default_nettype none
module cnt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       valid_o,
  input wire logic       is_carmichael_o,
  input wire logic [1:0] verdict_o
);
  import cnt_pkg::*;

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (is_carmichael_o == (verdict_o == VerdictPass)))
    else $error("flag disagrees with verdict");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request not taken");
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result held longer than one cycle");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without work");
endmodule

bind carmichael_number_test_core cnt_checker u_cnt_checker (.*);
`default_nettype wire

// ===== sim/carmichael_number_test_checker.sv =====
// Checker: watches requests and results of the Carmichael number test, predicts and compares.
`default_nettype none
module carmichael_number_test_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [cnt_pkg::NumberBits-1:0] number_i,
  input  wire logic                            busy_i,
  input  wire logic                            valid_i,
  input  wire logic                            is_carmichael_i,
  input  wire logic [1:0]                      verdict_i,
  output int                                   pending_o,
  output int                                   errors_o,
  output int                                   seen_o [4]
);
  timeunit 1ns;
  timeprecision 1ps;
  import cnt_pkg::*;

  typedef struct packed {
    num_t     number;
    logic     carmichael;
    verdict_e verdict;
  } carm_result_t;

  carm_result_t verdict_queue[$];

  // trial division to the square root of the shrinking cofactor
  function automatic verdict_e carm_classify(num_t n);
    longint unsigned rest, nm1, d;
    bit composite, div_fail;
    rest = n;
    composite = 0;
    div_fail = 0;
    if (n < 4) return VerdictPrime;
    nm1 = n - 1;
    for (d = 2; d <= rest / d; d++) begin
      if (rest % d == 0) begin
        composite = 1;
        rest = rest / d;
        if (rest % d == 0) return VerdictSquare;
        if (nm1 % (d - 1) != 0) div_fail = 1;
      end
    end
    if (!composite) return VerdictPrime;
    if (rest > 1 && nm1 % (rest - 1) != 0) div_fail = 1;
    return div_fail ? VerdictDivFail : VerdictPass;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    for (int i = 0; i < 4; i++) seen_o[i] = 0;
  end

  assign pending_o = verdict_queue.size();

  always @(posedge clk_i) begin
    carm_result_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        exp_r.number = number_i;
        exp_r.verdict = carm_classify(number_i);
        exp_r.carmichael = (exp_r.verdict == VerdictPass);
        verdict_queue.insert(verdict_queue.size(), exp_r);
      end
      if (valid_i) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result verdict=%0d", verdict_i));
        end else begin
          exp_r = verdict_queue.pop_front();
          seen_o[exp_r.verdict]++;
          if (verdict_i !== exp_r.verdict)
            report_mismatch($sformatf("n=%0d verdict got %0d want %0d",
                                      exp_r.number, verdict_i, exp_r.verdict));
          if (is_carmichael_i !== exp_r.carmichael)
            report_mismatch($sformatf("n=%0d is_carmichael got %0b want %0b",
                                      exp_r.number, is_carmichael_i, exp_r.carmichael));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb_carmichael_number_test_core.sv =====
// Testbench top: drives numbers into the Carmichael number test and reports the verdict.
`default_nettype none
module tb_carmichael_number_test_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cnt_pkg::*;

  logic clk_i, rst_ni, start_i;
  num_t number_i;
  logic busy_o, valid_o, is_carmichael_o;
  logic [1:0] verdict_o;
  int pending, errors;
  int seen [4];
  int sent;
  bit steady;

  carmichael_number_test_core dut (
    .clk_i, .rst_ni, .start_i, .number_i,
    .busy_o, .valid_o, .is_carmichael_o, .verdict_o
  );

  carmichael_number_test_checker checker_i (
    .clk_i, .rst_ni, .start_i, .number_i,
    .busy_i(busy_o), .valid_i(valid_o), .is_carmichael_i(is_carmichael_o),
    .verdict_i(verdict_o), .pending_o(pending), .errors_o(errors), .seen_o(seen)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

  // one request: optional idle gap, then start held until taken
  task automatic send_number(num_t n);
    if (!steady) begin
      while ($urandom_range(99) < 37) @(negedge clk_i);
    end
    while (busy_o) @(negedge clk_i);
    start_i = 1;
    number_i = n;
    @(negedge clk_i);
    start_i = 0;
    number_i = num_t'($urandom);
    sent++;
  endtask

  // product of small factors: wide values that still finish quickly
  function automatic num_t smooth_number();
    longint unsigned p, f;
    p = 1;
    forever begin
      f = $urandom_range(300, 2);
      if (p * f > 32'hFFFF_FFFF) return num_t'(p);
      p = p * f;
    end
  endfunction

  initial begin
    num_t directed [$] = '{0, 1, 2, 3, 4, 5, 9, 15, 561, 1105, 1729, 2465, 2821,
                           6601, 8911, 4093, 12, 45, 231, 65535, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'd3215031751};
    rst_ni = 0;
    start_i = 0;
    number_i = '0;
    sent = 0;
    steady = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    foreach (directed[i]) send_number(directed[i]);

    // wait for all outstanding results before the random phase
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < 100; i++) begin
      steady = (i >= 40 && i < 60);
      case ($urandom_range(9))
        0, 1:    send_number(smooth_number());
        2:       send_number({num_t'($urandom) >> 2, 2'b00});
        3:       send_number(num_t'($urandom_range(3)));
        default: send_number(num_t'($urandom_range(16383, 4)));
      endcase
    end

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);

    $display("Sent %0d numbers: %0d pass, %0d prime or small, %0d repeated factor,",
             sent, seen[VerdictPass], seen[VerdictPrime], seen[VerdictSquare]);
    $display("  %0d divisibility failures; %0d mismatches", seen[VerdictDivFail], errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
